@@ hdl/stereo_rms_peak_meter_top_assert.svh @@
// Assertion macros used by the level meter checker.
`ifndef STEREO_RMS_PEAK_METER_TOP_ASSERT_SVH
`define STEREO_RMS_PEAK_METER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SRPM_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: lbl");

// Next-cycle implication, disabled while reset is low.
`define SRPM_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: lbl");

`endif

@@ hdl/srpm_pkg.sv @@
// Package with sizes and shared types of the stereo level meter.
`timescale 1ns / 1ps
`default_nettype none
package srpm_pkg;

    localparam int MAX_FRAMES = 256;
    localparam int FRAME_W    = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W      = 31 + $clog2(MAX_FRAMES);
    localparam int DIV_W      = SUM_W + 2;
    localparam int STEP_W     = $clog2(DIV_W);
    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 34;
    localparam int ROOT_W     = 17;
    localparam int REM_W      = ROOT_W + 3;
    localparam int FCNT_W     = 9;
    localparam int IN_W       = 64;
    localparam int OUT_BITS   = 2 * ROOT_W + 2 * SAMPLE_W + FCNT_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        LS_IDLE,
        LS_DIV,
        LS_SQRT,
        LS_DONE
    } t_lane_state;

    typedef struct packed {
        logic take;
        logic close;
        logic ack;
    } t_lane_ctl;

    typedef struct packed {
        logic                done;
        logic [ROOT_W-1:0]   rms;
        logic [SAMPLE_W-1:0] peak;
    } t_lane_res;

endpackage
`default_nettype wire

@@ hdl/srpm_lane.sv @@
// One channel lane: peak and square-sum accumulation, then divide and square root.
`timescale 1ns / 1ps
`default_nettype none
module srpm_lane
    import srpm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_lane_ctl          i_ctl,
    input  wire logic [31:0]        i_word,
    input  wire logic [FRAME_W-1:0] i_frames,
    output t_lane_res               o_res
);

    t_lane_state         r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [SAMPLE_W-1:0] r_peak, n_peak;
    logic [SAMPLE_W-1:0] r_cpeak, n_cpeak;
    logic [FRAME_W-1:0]  r_div, n_div;
    logic [FRAME_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]    r_dq, n_dq;
    logic [SQ_W-1:0]     r_rad, n_rad;
    logic [REM_W-1:0]    r_srem, n_srem;
    logic [ROOT_W-1:0]   r_root, n_root;

    logic [SAMPLE_W-1:0] sample, mag;
    logic [2*SAMPLE_W-1:0] sq;
    logic [SUM_W-1:0]    sum_acc;
    logic [SAMPLE_W-1:0] peak_acc;
    logic [FRAME_W:0]    dtrial, ddiff;
    logic                dge;
    logic [DIV_W-1:0]    quo;
    logic [REM_W-1:0]    srs, strial;
    logic                sge;

    assign sample   = i_word[31:16];
    // Negating the most negative sample gives 0x8000, which reads as 32768.
    assign mag      = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;
    assign sq       = mag * mag;
    assign sum_acc  = r_sum + SUM_W'(sq);
    assign peak_acc = (mag > r_peak) ? mag : r_peak;

    assign dtrial = {r_rem, r_dq[DIV_W-1]};
    assign dge    = dtrial >= {1'b0, r_div};
    assign ddiff  = dtrial - {1'b0, r_div};
    assign quo    = {r_dq[DIV_W-2:0], dge};

    assign srs    = {r_srem[REM_W-3:0], r_rad[SQ_W-1:SQ_W-2]};
    assign strial = REM_W'({r_root, 2'b01});
    assign sge    = srs >= strial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
            r_step  <= '0;
            r_sum   <= '0;
            r_peak  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sum   <= n_sum;
            r_peak  <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cpeak <= n_cpeak;
        r_div   <= n_div;
        r_rem   <= n_rem;
        r_dq    <= n_dq;
        r_rad   <= n_rad;
        r_srem  <= n_srem;
        r_root  <= n_root;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_sum   = r_sum;
        n_peak  = r_peak;
        n_cpeak = r_cpeak;
        n_div   = r_div;
        n_rem   = r_rem;
        n_dq    = r_dq;
        n_rad   = r_rad;
        n_srem  = r_srem;
        n_root  = r_root;

        unique case (r_state)
            LS_IDLE: begin
            end
            LS_DIV: begin
                // Restoring division, one quotient bit per cycle.
                n_rem  = dge ? ddiff[FRAME_W-1:0] : dtrial[FRAME_W-1:0];
                n_dq   = quo;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    n_rad   = SQ_W'(quo);
                    n_srem  = '0;
                    n_root  = '0;
                    n_step  = '0;
                    n_state = LS_SQRT;
                end
            end
            LS_SQRT: begin
                // Digit-by-digit root, two radicand bits per cycle.
                n_rad  = {r_rad[SQ_W-3:0], 2'b00};
                n_srem = sge ? (srs - strial) : srs;
                n_root = {r_root[ROOT_W-2:0], sge};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(ROOT_W - 1)) begin
                    n_state = LS_DONE;
                end
            end
            LS_DONE: begin
                if (i_ctl.ack) begin
                    n_state = LS_IDLE;
                end
            end
            default: begin
                n_state = LS_IDLE;
            end
        endcase

        if (i_ctl.take) begin
            if (i_ctl.close) begin
                n_sum   = '0;
                n_peak  = '0;
                n_cpeak = peak_acc;
                n_dq    = DIV_W'({sum_acc, 2'b00});
                n_rem   = '0;
                n_div   = i_frames;
                n_step  = '0;
                n_state = LS_DIV;
            end else begin
                n_sum  = sum_acc;
                n_peak = peak_acc;
            end
        end
    end

    assign o_res.done = (r_state == LS_DONE);
    assign o_res.rms  = r_root;
    assign o_res.peak = r_cpeak;

endmodule
`default_nettype wire

@@ hdl/srpm_merge.sv @@
// Merging stage: joins both lane results and the frame count into the output register.
`timescale 1ns / 1ps
`default_nettype none
module srpm_merge
    import srpm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_lane_res          i_left,
    input  wire t_lane_res          i_right,
    input  wire logic [FRAME_W-1:0] i_frames,
    input  wire logic               i_ready,
    output logic                    o_valid,
    output logic [OUT_W-1:0]        o_data,
    output logic                    o_ack
);

    logic             r_valid, n_valid;
    logic [OUT_W-1:0] r_data;
    logic             load;

    assign load = i_left.done && i_right.done && (!r_valid || i_ready);

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= OUT_W'({FCNT_W'(i_frames), i_right.peak, i_left.peak,
                              i_right.rms, i_left.rms});
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_ack   = load;

endmodule
`default_nettype wire

@@ hdl/stereo_rms_peak_meter_top.sv @@
// A closing word runs the divider steps, then the root steps in each lane, and the result then
// loads into the output register.
// Throughput: one frame word per cycle, but while the lanes are busy a closing word waits
// until the previous result has moved into the output register.
// Reset: synchronous, active low; clears accumulators, frame count and all valid flags.
`timescale 1ns / 1ps
`default_nettype none
module stereo_rms_peak_meter_top
    import srpm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata from bit 0: left_word[31:0], right_word[63:32]
    input  wire logic [IN_W-1:0]  i_s_axis_tdata,
    input  wire logic             i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    // tdata from bit 0: rms_left[16:0], rms_right[33:17], peak_left[49:34],
    // peak_right[65:50], frame_count[74:66], zero fill [79:75]
    output logic [OUT_W-1:0]      o_m_axis_tdata
);

    logic [FRAME_W-1:0] r_frames, n_frames;
    logic [FRAME_W-1:0] r_chunk_n, n_chunk_n;
    logic               r_busy, n_busy;
    logic [FRAME_W-1:0] count_inc;
    logic               ends, take, ack;
    t_lane_ctl          ctl;
    t_lane_res          res_l, res_r;

    assign count_inc = r_frames + FRAME_W'(1);
    assign ends      = i_s_axis_tlast || (count_inc == FRAME_W'(MAX_FRAMES));
    // Mid-chunk words keep flowing while the lanes still work on the previous chunk.
    assign o_s_axis_tready = !r_busy || !ends;
    assign take      = i_s_axis_tvalid && o_s_axis_tready;

    assign ctl.take  = take;
    assign ctl.close = take && ends;
    assign ctl.ack   = ack;

    always_comb begin
        n_frames  = r_frames;
        n_chunk_n = r_chunk_n;
        n_busy    = r_busy;
        if (ack) begin
            n_busy = 1'b0;
        end
        if (take) begin
            n_frames = ends ? '0 : count_inc;
            if (ends) begin
                n_chunk_n = count_inc;
                n_busy    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= '0;
            r_busy   <= 1'b0;
        end else begin
            r_frames <= n_frames;
            r_busy   <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chunk_n <= n_chunk_n;
    end

    srpm_lane u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_word   (i_s_axis_tdata[31:0]),
        .i_frames (count_inc),
        .o_res    (res_l)
    );

    srpm_lane u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_word   (i_s_axis_tdata[63:32]),
        .i_frames (count_inc),
        .o_res    (res_r)
    );

    srpm_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_left   (res_l),
        .i_right  (res_r),
        .i_frames (r_chunk_n),
        .i_ready  (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_data   (o_m_axis_tdata),
        .o_ack    (ack)
    );

endmodule
`default_nettype wire

@@ hdl/srpm_checker.sv @@
// Port-level checker for the stereo level meter and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_rms_peak_meter_top_assert.svh"
module srpm_checker
    import srpm_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_s_axis_tvalid,
    input wire logic             o_s_axis_tready,
    input wire logic [IN_W-1:0]  i_s_axis_tdata,
    input wire logic             i_s_axis_tlast,
    input wire logic             o_m_axis_tvalid,
    input wire logic             i_m_axis_tready,
    input wire logic [OUT_W-1:0] o_m_axis_tdata
);

    // A stalled result word holds.
    `SRPM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // Every chunk covers at least one frame.
    `SRPM_ASSERT_IMPLY(a_count_nonzero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[74:66] != 9'd0)
    // Peaks never exceed the magnitude of the most negative sample.
    `SRPM_ASSERT_IMPLY(a_peak_range, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tdata[49:34] <= 16'h8000) && (o_m_axis_tdata[65:50] <= 16'h8000))
    // The root of a full-scale chunk is exactly one, so the RMS stays in 0..65536.
    `SRPM_ASSERT_IMPLY(a_rms_range, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tdata[16:0] <= 17'h10000) && (o_m_axis_tdata[33:17] <= 17'h10000))

endmodule

bind stereo_rms_peak_meter_top srpm_checker u_srpm_checker (.*);
`default_nettype wire
